// ===== design/btpt_pkg.sv =====
// Shared codes and fixed field widths of the binary trie prefix table.
package btpt_pkg;

    localparam int CMD_W    = 2;
    localparam int ADDR_W   = 32;
    localparam int MASK_W   = 32;
    localparam int STATUS_W = 2;
    localparam int PREFIX_W = 32;
    localparam int MLEN_W   = 6;

    localparam int IN_TDATA_W  = 72;  // 66 bits of fields, padded to bytes
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_UNUSED    = 2'd3
    } t_status;

endpackage

// ===== design/binary_trie_prefix_table.sv =====
// Top level of the binary trie prefix table: sequencer, root node and free list.
//
// A one-bit-per-level binary trie of prefixes with longest prefix match. Each input
// beat carries a command (insert, delete, lookup), an address and a netmask; the
// prefix length is KEY_BITS minus the trailing zeros of the mask (0 for a zero
// mask). Exactly one result beat comes back per command: status (0 done/matched,
// 1 not found, 2 node store full), and for a matched lookup the address masked to
// the matched length plus that length. Nodes live in a NODES-deep node memory; the
// root is held in flip-flops. Free nodes come first from a LIFO of released nodes
// (kept in a second memory), then from a counter of never-used nodes, so no clearing
// pass is needed after reset. One command is handled at a time: the slave side is
// ready only when the sequencer is idle. A command is accepted and its prefix length
// is set up, then the trie is walked with one node-memory read per trie level
// visited; an insert then links each new node under the last one, with an extra step
// to fetch the next head when the node came from the released list, and marks the
// leaf; a delete prunes emptied nodes, climbing to the parent after each, and ends
// with a final write; last the result is presented. The result sits in an output
// register, so the next command can be taken while it waits; a command that
// finishes while the previous result is still unaccepted holds until that beat has
// gone.
module binary_trie_prefix_table #(
    parameter int NODES    = 1024,
    parameter int KEY_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave side
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [1:0] command, [33:2] address, [65:34] netmask, [71:66] zero
    input  logic [btpt_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // master side
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [1:0] status, [33:2] match_prefix, [39:34] match_length
    output logic [btpt_pkg::OUT_TDATA_W-1:0]   o_m_tdata
);

    localparam int IDX_W = $clog2(NODES);
    localparam int LEN_W = $clog2(KEY_BITS + 1);
    localparam int CNT_W = IDX_W + 1;

    typedef struct packed {
        logic             leaf;
        logic [IDX_W-1:0] parent;
        logic [IDX_W-1:0] child1;
        logic [IDX_W-1:0] child0;
    } t_node;

    localparam int NODE_W = $bits(t_node);

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_WALK, S_ALLOC, S_HEAD, S_LEAF, S_PRUNE, S_PFETCH, S_DONE
    } t_state;

    // sequencer registers
    t_state                    r_state,    n_state;
    btpt_pkg::t_cmd            r_cmd,      n_cmd;
    logic [KEY_BITS-1:0]       r_key,      n_key;
    logic [KEY_BITS-1:0]       r_mask,     n_mask;
    logic [LEN_W-1:0]          r_len,      n_len;
    logic [LEN_W-1:0]          r_lvl,      n_lvl;
    logic [IDX_W-1:0]          r_cur,      n_cur;
    logic [IDX_W-1:0]          r_prev,     n_prev;
    t_node                     r_nd,       n_nd;
    logic                      r_found,    n_found;
    logic [LEN_W-1:0]          r_mlen,     n_mlen;
    btpt_pkg::t_status         r_status,   n_status;
    // root node
    logic [IDX_W-1:0]          r_root_c0,  n_root_c0;
    logic [IDX_W-1:0]          r_root_c1,  n_root_c1;
    logic                      r_root_leaf, n_root_leaf;
    // free list
    logic [IDX_W-1:0]          r_free_head, n_free_head;
    logic [CNT_W-1:0]          r_fresh,    n_fresh;
    logic [CNT_W-1:0]          r_free_cnt, n_free_cnt;
    // output register
    logic                      r_out_valid, n_out_valid;
    logic [btpt_pkg::OUT_TDATA_W-1:0] r_out_data, n_out_data;

    // memory ports
    logic              node_we;
    logic [IDX_W-1:0]  node_raddr;
    t_node             node_wdata;
    logic [NODE_W-1:0] node_q;
    logic              fn_we;
    logic [IDX_W-1:0]  fn_waddr;
    logic [IDX_W-1:0]  fn_wdata;
    logic [IDX_W-1:0]  fn_q;

    // datapath helpers
    t_node               nd;
    t_node               root_nd;
    logic [KEY_BITS-1:0] key_sh;
    logic                key_bit;
    logic [IDX_W-1:0]    child;
    logic [KEY_BITS-1:0] low_bit;
    logic [LEN_W-1:0]    tz;
    logic [LEN_W-1:0]    walk_len;
    logic [LEN_W-1:0]    need;
    logic                fresh_hit;
    logic [CNT_W-1:0]    fresh_inc;
    logic [KEY_BITS-1:0] pfx_mask;
    t_node               node_upd;  // node to write back (root goes to flip-flops)
    logic                node_wr;

    btpt_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (r_cur),
        .i_wdata (node_wdata),
        .i_raddr (node_raddr),
        .o_rdata (node_q)
    );

    btpt_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (fn_we),
        .i_waddr (fn_waddr),
        .i_wdata (fn_wdata),
        .i_raddr (r_free_head),
        .o_rdata (fn_q)
    );

    // current node: root from flip-flops, others from the registered RAM read
    always_comb begin
        root_nd.leaf   = r_root_leaf;
        root_nd.parent = '0;
        root_nd.child1 = r_root_c1;
        root_nd.child0 = r_root_c0;
        nd = (r_cur == '0) ? root_nd : t_node'(node_q);
    end

    assign key_sh  = r_key << r_lvl;
    assign key_bit = key_sh[KEY_BITS-1];
    assign child   = key_bit ? nd.child1 : nd.child0;

    // prefix length: isolate lowest set mask bit, encode its position
    always_comb begin
        low_bit = r_mask & (~r_mask + 1'b1);
        tz = '0;
        for (int i = 0; i < KEY_BITS; i++) begin
            if (low_bit[i]) begin
                tz = tz | LEN_W'(i);
            end
        end
        walk_len = (r_mask == '0) ? '0 : LEN_W'(KEY_BITS) - tz;
    end

    assign need      = r_len - r_lvl;
    assign fresh_hit = (r_fresh < CNT_W'(NODES)) && (r_free_head == r_fresh[IDX_W-1:0]);
    assign fresh_inc = r_fresh + 1'b1;
    assign pfx_mask  = ~({KEY_BITS{1'b1}} >> r_mlen);
    assign node_we    = node_wr && (r_cur != '0);
    assign node_wdata = node_upd;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_mask      = r_mask;
        n_len       = r_len;
        n_lvl       = r_lvl;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_nd        = r_nd;
        n_found     = r_found;
        n_mlen      = r_mlen;
        n_status    = r_status;
        n_root_c0   = r_root_c0;
        n_root_c1   = r_root_c1;
        n_root_leaf = r_root_leaf;
        n_free_head = r_free_head;
        n_fresh     = r_fresh;
        n_free_cnt  = r_free_cnt;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        node_raddr  = r_cur;
        node_wr     = 1'b0;
        node_upd    = r_nd;
        fn_we       = 1'b0;
        fn_waddr    = r_cur;
        fn_wdata    = r_free_head;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_cmd   = btpt_pkg::t_cmd'(i_s_tdata[1:0]);
                    n_key   = i_s_tdata[2 +: KEY_BITS];
                    n_mask  = i_s_tdata[34 +: KEY_BITS];
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_len    = walk_len;
                n_lvl    = '0;
                n_cur    = '0;
                n_found  = 1'b0;
                n_mlen   = '0;
                n_status = btpt_pkg::ST_OK;
                if (r_cmd == btpt_pkg::CMD_NONE) begin
                    n_status = btpt_pkg::ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                case (r_cmd)
                    btpt_pkg::CMD_INSERT: begin
                        if (r_lvl < r_len && child != '0) begin
                            n_cur      = child;
                            node_raddr = child;
                            n_lvl      = r_lvl + 1'b1;
                        end else begin
                            n_nd = nd;
                            if (32'(need) > 32'(r_free_cnt)) begin
                                n_status = btpt_pkg::ST_FULL;
                                n_state  = S_DONE;
                            end else if (r_lvl == r_len) begin
                                n_state = S_LEAF;
                            end else begin
                                n_state = S_ALLOC;
                            end
                        end
                    end
                    btpt_pkg::CMD_DELETE: begin
                        if (r_lvl < r_len) begin
                            if (child == '0) begin
                                n_status = btpt_pkg::ST_NOT_FOUND;
                                n_state  = S_DONE;
                            end else begin
                                n_cur      = child;
                                node_raddr = child;
                                n_lvl      = r_lvl + 1'b1;
                            end
                        end else if (!nd.leaf) begin
                            n_status = btpt_pkg::ST_NOT_FOUND;
                            n_state  = S_DONE;
                        end else begin
                            n_nd      = nd;
                            n_nd.leaf = 1'b0;
                            n_state   = S_PRUNE;
                        end
                    end
                    default: begin  // lookup
                        if (nd.leaf) begin
                            n_found = 1'b1;
                            n_mlen  = r_lvl;
                        end
                        if (r_lvl == LEN_W'(KEY_BITS) || child == '0) begin
                            n_status = (r_found || nd.leaf) ? btpt_pkg::ST_OK
                                                            : btpt_pkg::ST_NOT_FOUND;
                            n_state  = S_DONE;
                        end else begin
                            n_cur      = child;
                            node_raddr = child;
                            n_lvl      = r_lvl + 1'b1;
                        end
                    end
                endcase
            end
            S_ALLOC: begin
                // link head of free list under the current node
                node_wr = 1'b1;
                if (key_bit) begin
                    node_upd.child1 = r_free_head;
                end else begin
                    node_upd.child0 = r_free_head;
                end
                if (r_cur == '0) begin
                    n_root_c0 = node_upd.child0;
                    n_root_c1 = node_upd.child1;
                end
                n_nd.leaf   = 1'b0;
                n_nd.parent = r_cur;
                n_nd.child0 = '0;
                n_nd.child1 = '0;
                n_cur       = r_free_head;
                n_lvl       = r_lvl + 1'b1;
                n_free_cnt  = r_free_cnt - 1'b1;
                if (fresh_hit) begin
                    n_fresh     = fresh_inc;
                    n_free_head = (fresh_inc == CNT_W'(NODES)) ? '0 : fresh_inc[IDX_W-1:0];
                    n_state     = (r_lvl + 1'b1 == r_len) ? S_LEAF : S_ALLOC;
                end else begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                n_free_head = fn_q;
                n_state     = (r_lvl == r_len) ? S_LEAF : S_ALLOC;
            end
            S_LEAF: begin
                node_wr       = 1'b1;
                node_upd.leaf = 1'b1;
                if (r_cur == '0) begin
                    n_root_leaf = 1'b1;
                end
                n_status = btpt_pkg::ST_OK;
                n_state  = S_DONE;
            end
            S_PRUNE: begin
                if (r_cur != '0 && !r_nd.leaf && r_nd.child0 == '0 && r_nd.child1 == '0) begin
                    // release this node and climb to its parent
                    fn_we       = 1'b1;
                    n_free_head = r_cur;
                    n_free_cnt  = r_free_cnt + 1'b1;
                    n_prev      = r_cur;
                    n_cur       = r_nd.parent;
                    node_raddr  = r_nd.parent;
                    n_state     = S_PFETCH;
                end else begin
                    node_wr = 1'b1;
                    if (r_cur == '0) begin
                        n_root_c0   = r_nd.child0;
                        n_root_c1   = r_nd.child1;
                        n_root_leaf = r_nd.leaf;
                    end
                    n_state = S_DONE;
                end
            end
            S_PFETCH: begin
                n_nd = nd;
                if (nd.child0 == r_prev) begin
                    n_nd.child0 = '0;
                end
                if (nd.child1 == r_prev) begin
                    n_nd.child1 = '0;
                end
                n_state = S_PRUNE;
            end
            S_DONE: begin
                if (!r_out_valid) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    n_out_data[1:0] = r_status;
                    if (r_cmd == btpt_pkg::CMD_LOOKUP && r_status == btpt_pkg::ST_OK) begin
                        n_out_data[33:2]  = 32'(r_key & pfx_mask);
                        n_out_data[39:34] = 6'(r_mlen);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_root_c0   <= '0;
            r_root_c1   <= '0;
            r_root_leaf <= 1'b0;
            r_free_head <= IDX_W'(1);
            r_fresh     <= CNT_W'(1);
            r_free_cnt  <= CNT_W'(NODES - 1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_root_c0   <= n_root_c0;
            r_root_c1   <= n_root_c1;
            r_root_leaf <= n_root_leaf;
            r_free_head <= n_free_head;
            r_fresh     <= n_fresh;
            r_free_cnt  <= n_free_cnt;
            r_out_valid <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_mask     <= n_mask;
        r_len      <= n_len;
        r_lvl      <= n_lvl;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_nd       <= n_nd;
        r_found    <= n_found;
        r_mlen     <= n_mlen;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== design/btpt_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module btpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ===== design/btpt_checker.sv =====
// Port-level checks for the binary trie prefix table, bound to the top level.
module btpt_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [btpt_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    // one command at a time: not ready the cycle after a beat is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("slave side ready straight after an accepted beat");

    // a waiting result beat stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat dropped or changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[1:0] != btpt_pkg::ST_UNUSED)
        else $error("unused status code");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[1:0] != btpt_pkg::ST_OK
            |-> o_m_tdata[39:2] == '0)
        else $error("match fields set on a failed command");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[39:34] <= 6'd32)
        else $error("match length beyond 32");

endmodule

bind binary_trie_prefix_table btpt_checker u_btpt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
